@@ rtl/mrfri_pkg.sv @@
// Package with the codes, widths and entry type of the frame ring index.
package mrfri_pkg;
    localparam int SLOT_W = 11;
    localparam int RSLOT_W = 10;
    localparam int LAP_W = 32;
    localparam int POS_W = 24;
    localparam int BL_W = 11;

    localparam logic [2:0] CMD_PUT = 3'd0;
    localparam logic [2:0] CMD_REQUEST = 3'd1;
    localparam logic [2:0] CMD_FREE = 3'd2;
    localparam logic [2:0] CMD_READ = 3'd3;
    localparam logic [2:0] CMD_RESET = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_SYNC = 3'd2;
    localparam logic [2:0] ST_TYPE = 3'd3;
    localparam logic [2:0] ST_NOREADER = 3'd4;
    localparam logic [2:0] ST_NODATA = 3'd5;

    localparam logic [7:0] TYPE_I = 8'hF8;
    localparam logic [7:0] TYPE_P = 8'hF9;
    localparam logic [7:0] TYPE_A = 8'hFA;
    localparam logic [23:0] SYNC_WORD = 24'h000001;

    localparam logic CFG_BUFFER_BYTES = 1'b0;
    localparam logic CFG_INITIAL_FRAMES = 1'b1;

    typedef struct packed {
        logic [23:0] start;
        logic [23:0] length;
        logic [63:0] pts;
        logic [63:0] stamp;
        logic [7:0]  ftype;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  granted;
        logic [23:0] start;
        logic [23:0] nbytes;
        logic [63:0] pts;
        logic [63:0] stamp;
        logic [7:0]  ftype;
        logic [10:0] backlog;
    } result_t;
endpackage

@@ rtl/multi_reader_frame_ring_index.sv @@
// Top level of the frame ring index: entry memory, reader table and command sequencer.
// Each command takes one item and gives one result item. A put, request, free or reader reset
// goes from S_IDLE to S_OUT, which registers its result once the output is free. A read adds
// S_ISSUE and S_EVAL per realignment pass (a registered memory read), then S_FETCH and
// S_FINISH for the final entry fetch. The next item is accepted once the previous result has
// left the sequencer. Frame entries hold no reset value; a never-written entry reads garbage.
module multi_reader_frame_ring_index #(
    parameter int FRAME_SLOTS = 512,
    parameter int KEYFRAME_SLOTS = 64,
    parameter int READERS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // reader_id, sync_code, frame_type, frame_bytes, frame_pts, wall_time, zero fill
    input  logic [191:0] s_tdata,
    // cmd
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // granted_reader, start_pos, out_bytes, out_pts, out_time, out_type, backlog, zero fill
    output logic [199:0] m_tdata,
    // status
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [23:0]  cfg_data
);
    localparam int AW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int KW = (KEYFRAME_SLOTS > 1) ? $clog2(KEYFRAME_SLOTS) : 1;
    localparam int PW = 2;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_EVAL, S_FETCH, S_FINISH, S_OUT
    } state_t;

    state_t state_reg;
    mrfri_pkg::entry_t mem [FRAME_SLOTS];
    mrfri_pkg::entry_t rdata_reg;
    logic rd_ok_reg;

    logic [23:0] buffer_bytes_reg;
    logic [23:0] write_offset_reg;
    logic [mrfri_pkg::SLOT_W-1:0] write_slot_reg;
    logic [mrfri_pkg::SLOT_W-1:0] lap_frames_reg;
    logic [mrfri_pkg::SLOT_W-1:0] newest_key_reg;
    logic [KW-1:0] keyframe_slot_reg;
    logic [31:0] lap_count_reg;

    logic rd_busy_reg [READERS];
    logic rd_sync_reg [READERS];
    logic [mrfri_pkg::RSLOT_W-1:0] rd_slot_reg [READERS];
    logic [31:0] rd_lap_reg [READERS];

    logic [2:0] rid_reg;
    logic [mrfri_pkg::RSLOT_W-1:0] wslot_reg;
    logic [31:0] wlap_reg;
    logic [PW-1:0] pass_reg;
    mrfri_pkg::result_t res_reg;
    mrfri_pkg::result_t out_reg;
    logic out_valid_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr;
    mrfri_pkg::entry_t mem_wdata;

    logic [2:0]  in_rid;
    logic [23:0] in_sync;
    logic [7:0]  in_type;
    logic [23:0] in_bytes;
    logic [63:0] in_pts;
    logic [63:0] in_time;

    assign in_rid = s_tdata[2:0];
    assign in_sync = s_tdata[26:3];
    assign in_type = s_tdata[34:27];
    assign in_bytes = s_tdata[58:35];
    assign in_pts = s_tdata[122:59];
    assign in_time = s_tdata[186:123];

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.status;
    assign m_tdata = {2'b00, out_reg.backlog, out_reg.ftype, out_reg.stamp, out_reg.pts,
                      out_reg.nbytes, out_reg.start, out_reg.granted};

    function automatic logic [mrfri_pkg::SLOT_W-1:0] clamp_frames(input logic [9:0] v);
        if ({1'b0, v} > mrfri_pkg::SLOT_W'(FRAME_SLOTS)) begin
            return mrfri_pkg::SLOT_W'(FRAME_SLOTS);
        end
        return {1'b0, v};
    endfunction

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[wslot_reg[AW-1:0]];
        rd_ok_reg <= ({1'b0, wslot_reg} < mrfri_pkg::SLOT_W'(FRAME_SLOTS));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_waddr = write_slot_reg[AW-1:0];
        mem_wdata = '0;
        if (state_reg == S_IDLE && s_tvalid && s_tuser == mrfri_pkg::CMD_PUT
            && in_bytes != 24'd0 && in_bytes <= buffer_bytes_reg
            && in_sync == mrfri_pkg::SYNC_WORD
            && (in_type == mrfri_pkg::TYPE_I || in_type == mrfri_pkg::TYPE_P
                || in_type == mrfri_pkg::TYPE_A)) begin
            mem_we = 1'b1;
            if (write_offset_reg > buffer_bytes_reg
                || buffer_bytes_reg - write_offset_reg < in_bytes) begin
                mem_waddr = '0;
                mem_wdata.start = '0;
            end else begin
                mem_wdata.start = write_offset_reg;
            end
            mem_wdata.length = in_bytes;
            mem_wdata.pts = in_pts;
            mem_wdata.stamp = in_time;
            mem_wdata.ftype = in_type;
        end
    end

    always_ff @(posedge aclk) begin
        automatic mrfri_pkg::result_t r = '0;
        automatic logic [23:0] wo = '0;
        automatic logic [mrfri_pkg::SLOT_W-1:0] ws = '0;
        automatic logic [mrfri_pkg::SLOT_W-1:0] lf = '0;
        automatic logic [mrfri_pkg::RSLOT_W-1:0] ts = '0;
        automatic logic [31:0] tl = '0;
        automatic logic [31:0] diff = '0;
        automatic logic [23:0] sv = '0;
        automatic logic [11:0] tot = '0;
        automatic logic found = 1'b0;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            buffer_bytes_reg <= 24'd4194304;
            write_offset_reg <= '0;
            write_slot_reg <= '0;
            lap_frames_reg <= clamp_frames(10'd512);
            newest_key_reg <= '0;
            keyframe_slot_reg <= '0;
            lap_count_reg <= '0;
            for (int i = 0; i < READERS; i++) begin
                rd_busy_reg[i] <= 1'b0;
                rd_sync_reg[i] <= 1'b0;
                rd_slot_reg[i] <= '0;
                rd_lap_reg[i] <= '0;
            end
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == mrfri_pkg::CFG_BUFFER_BYTES) begin
                    buffer_bytes_reg <= cfg_data;
                end else begin
                    lap_frames_reg <= clamp_frames(cfg_data[9:0]);
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        rid_reg <= in_rid;
                        r.status = mrfri_pkg::ST_ILLEGAL;
                        state_reg <= S_OUT;
                        case (s_tuser)
                            mrfri_pkg::CMD_PUT: begin
                                if (in_bytes == 24'd0 || in_bytes > buffer_bytes_reg) begin
                                    r.status = mrfri_pkg::ST_ILLEGAL;
                                end else if (in_sync != mrfri_pkg::SYNC_WORD) begin
                                    r.status = mrfri_pkg::ST_SYNC;
                                end else if (in_type != mrfri_pkg::TYPE_I
                                             && in_type != mrfri_pkg::TYPE_P
                                             && in_type != mrfri_pkg::TYPE_A) begin
                                    r.status = mrfri_pkg::ST_TYPE;
                                end else begin
                                    wo = write_offset_reg;
                                    ws = write_slot_reg;
                                    lf = lap_frames_reg;
                                    tl = lap_count_reg;
                                    if (wo > buffer_bytes_reg
                                        || buffer_bytes_reg - wo < in_bytes) begin
                                        lf = ws;
                                        ws = '0;
                                        tl = tl + 32'd1;
                                        wo = '0;
                                    end
                                    r.status = mrfri_pkg::ST_OK;
                                    r.start = wo;
                                    if (in_type == mrfri_pkg::TYPE_I) begin
                                        if (keyframe_slot_reg == KW'(KEYFRAME_SLOTS - 1)) begin
                                            keyframe_slot_reg <= '0;
                                        end else begin
                                            keyframe_slot_reg <= keyframe_slot_reg + 1'b1;
                                        end
                                        newest_key_reg <= ws;
                                    end
                                    wo = wo + in_bytes;
                                    ws = ws + 1'b1;
                                    if (ws > lf) begin
                                        lf = ws;
                                    end
                                    if (ws >= mrfri_pkg::SLOT_W'(FRAME_SLOTS)) begin
                                        lf = ws;
                                        ws = '0;
                                        tl = tl + 32'd1;
                                        wo = '0;
                                    end
                                    write_offset_reg <= wo;
                                    write_slot_reg <= ws;
                                    lap_frames_reg <= lf;
                                    lap_count_reg <= tl;
                                end
                            end
                            mrfri_pkg::CMD_REQUEST: begin
                                r.status = mrfri_pkg::ST_NOREADER;
                                found = 1'b0;
                                for (int i = 0; i < READERS; i++) begin
                                    if (!found && !rd_busy_reg[i]) begin
                                        found = 1'b1;
                                        rd_busy_reg[i] <= 1'b1;
                                        rd_slot_reg[i] <= '0;
                                        rd_lap_reg[i] <= '0;
                                        rd_sync_reg[i] <= 1'b1;
                                        r.granted = 3'(i);
                                        r.status = mrfri_pkg::ST_OK;
                                    end
                                end
                            end
                            mrfri_pkg::CMD_FREE: begin
                                if (32'(in_rid) < READERS) begin
                                    rd_busy_reg[in_rid] <= 1'b0;
                                    rd_slot_reg[in_rid] <= '0;
                                    rd_lap_reg[in_rid] <= '0;
                                    rd_sync_reg[in_rid] <= 1'b0;
                                    r.status = mrfri_pkg::ST_OK;
                                end
                            end
                            mrfri_pkg::CMD_RESET: begin
                                if (32'(in_rid) < READERS) begin
                                    rd_busy_reg[in_rid] <= 1'b1;
                                    rd_sync_reg[in_rid] <= 1'b0;
                                    rd_slot_reg[in_rid] <= newest_key_reg[mrfri_pkg::RSLOT_W-1:0];
                                    rd_lap_reg[in_rid] <= (newest_key_reg <= write_slot_reg)
                                        ? lap_count_reg : lap_count_reg - 32'd1;
                                    r.status = mrfri_pkg::ST_OK;
                                end
                            end
                            mrfri_pkg::CMD_READ: begin
                                if (32'(in_rid) < READERS) begin
                                    state_reg <= S_ISSUE;
                                    pass_reg <= '0;
                                    if (rd_sync_reg[in_rid]) begin
                                        wslot_reg <= newest_key_reg[mrfri_pkg::RSLOT_W-1:0];
                                        wlap_reg <= (newest_key_reg <= write_slot_reg)
                                            ? lap_count_reg : lap_count_reg - 32'd1;
                                    end else begin
                                        wslot_reg <= rd_slot_reg[in_rid];
                                        wlap_reg <= rd_lap_reg[in_rid];
                                    end
                                    rd_busy_reg[in_rid] <= rd_busy_reg[in_rid] | rd_sync_reg[in_rid];
                                    rd_sync_reg[in_rid] <= 1'b0;
                                end
                            end
                            default: begin
                                r.status = mrfri_pkg::ST_ILLEGAL;
                            end
                        endcase
                        res_reg <= r;
                    end
                end
                S_ISSUE: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    r.status = mrfri_pkg::ST_NODATA;
                    ts = wslot_reg;
                    tl = wlap_reg;
                    if (wlap_reg > lap_count_reg) begin
                        lap_count_reg <= '0;
                        ts = newest_key_reg[mrfri_pkg::RSLOT_W-1:0];
                        tl = '0;
                        state_reg <= (pass_reg == PW'(2)) ? S_OUT : S_ISSUE;
                    end else if ({1'b0, wslot_reg} == write_slot_reg
                                 && wlap_reg == lap_count_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        sv = rd_ok_reg ? rdata_reg.start : 24'd0;
                        if ({1'b0, ts} >= lap_frames_reg && tl < lap_count_reg) begin
                            ts = '0;
                            tl = lap_count_reg;
                        end
                        diff = lap_count_reg - tl;
                        if (ts == '0 && tl == lap_count_reg && wslot_reg != '0
                            && write_slot_reg == '0) begin
                            state_reg <= S_OUT;
                        end else if (tl != wlap_reg && write_slot_reg == '0) begin
                            state_reg <= S_OUT;
                        end else if ((diff == 32'd1 && sv < write_offset_reg)
                                     || diff >= 32'd2) begin
                            ts = newest_key_reg[mrfri_pkg::RSLOT_W-1:0];
                            tl = lap_count_reg;
                            state_reg <= (pass_reg == PW'(2)) ? S_OUT : S_ISSUE;
                        end else begin
                            state_reg <= S_FETCH;
                        end
                    end
                    pass_reg <= pass_reg + 1'b1;
                    wslot_reg <= ts;
                    wlap_reg <= tl;
                    rd_slot_reg[rid_reg] <= ts;
                    rd_lap_reg[rid_reg] <= tl;
                    res_reg <= r;
                end
                S_FETCH: begin
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    r.status = mrfri_pkg::ST_OK;
                    if (rd_ok_reg) begin
                        r.start = rdata_reg.start;
                        r.nbytes = rdata_reg.length;
                        r.pts = rdata_reg.pts;
                        r.stamp = rdata_reg.stamp;
                        r.ftype = rdata_reg.ftype;
                    end
                    ts = wslot_reg + 1'b1;
                    if (wlap_reg == lap_count_reg) begin
                        r.backlog = ({1'b0, ts} < write_slot_reg)
                            ? write_slot_reg - {1'b0, ts} : '0;
                    end else begin
                        tot = {1'b0, lap_frames_reg} + {1'b0, write_slot_reg};
                        if (tot > {2'b00, ts}) begin
                            tot = tot - {2'b00, ts};
                        end else begin
                            tot = '0;
                        end
                        r.backlog = tot[11] ? 11'h7FF : tot[10:0];
                    end
                    rd_slot_reg[rid_reg] <= ts;
                    res_reg <= r;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_reg <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
